// File: sv/rgb_to_hsi_converter_assert.svh
// Assertion macros for the RGB to HSI converter checker.
`ifndef RGB_TO_HSI_CONVERTER_ASSERT_SVH
`define RGB_TO_HSI_CONVERTER_ASSERT_SVH

// Assert an implication under clock and reset.
`define RTH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert an implication whose consequent must hold in the next cycle.
`define RTH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rth_pkg.sv
// Package with widths, constants and the arctangent table for the HSI converter.
`default_nettype none
package rth_pkg;
  localparam int FracBits    = 12;
  localparam int ChanBits    = 8;
  localparam int OutBits     = FracBits + 1;
  localparam int CordicSteps = 28;
  localparam int SumBits     = ChanBits + 2;
  localparam int XyBits      = 32;
  localparam int Sqrt3Q16    = 113512;
  localparam int FullScale   = (1 << ChanBits) - 1;
  localparam int IntDiv      = 6 * FullScale;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;

  // Reciprocal of the intensity divisor; exact floor for any numerator that fits.
  localparam int IntNumBits   = FracBits + SumBits + 2;
  localparam int IntShift     = IntNumBits + $clog2(IntDiv);
  localparam int IntRecipBits = IntNumBits + 1;
  localparam int IntProdBits  = IntNumBits + IntRecipBits;
  localparam longint IntRecip =
    ((longint'(1) << IntShift) + longint'(IntDiv) - 1) / longint'(IntDiv);

  typedef logic [ChanBits-1:0] chan_t;
  typedef logic [OutBits-1:0]  frac_t;
  typedef logic [SumBits-1:0]  sum_t;
  typedef logic signed [XyBits-1:0] xy_t;
  typedef logic [31:0] ang_t;

  // Arctangent of 2^-i in turns scaled by 2^32.
  function automatic ang_t atan_turn(input logic [4:0] idx);
    ang_t v;
    case (idx)
      5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;       5'd21: v = 32'd326;
      5'd22: v = 32'd163;       5'd23: v = 32'd81;
      5'd24: v = 32'd41;        5'd25: v = 32'd20;
      5'd26: v = 32'd10;        5'd27: v = 32'd5;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// File: sv/rth_cordic_stage.sv
// One CORDIC vectoring iteration with its pipeline register.
`default_nettype none
module rth_cordic_stage (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [4:0]   idx_i,
  input  wire rth_pkg::xy_t  x_i,
  input  wire rth_pkg::xy_t  y_i,
  input  wire rth_pkg::ang_t ang_i,
  output rth_pkg::xy_t  x_o,
  output rth_pkg::xy_t  y_o,
  output rth_pkg::ang_t ang_o
);
  import rth_pkg::*;
  xy_t  x_d, y_d, x_q, y_q, dx, dy;
  ang_t ang_d, ang_q, t;

  // Rotate toward the x axis using the old x and y.
  always_comb begin
    dx = y_i >>> idx_i;
    dy = x_i >>> idx_i;
    t  = atan_turn(idx_i);
    if (y_i > 0) begin
      x_d = x_i + dx; y_d = y_i - dy; ang_d = ang_i + t;
    end else begin
      x_d = x_i - dx; y_d = y_i + dy; ang_d = ang_i - t;
    end
  end

  // Advance when the pipeline moves.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d; y_q <= y_d; ang_q <= ang_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign ang_o = ang_q;
endmodule
`default_nettype wire

// File: sv/rgb_to_hsi_converter.sv
// Top level: pipelined RGB to HSI pixel converter.
// Stages: one prep, one vector setup, 28 CORDIC stages, one output stage.
// Throughput: one pixel per cycle while no stall holds the pipeline.
// A stall freezes every stage; input stall follows output stall and output valid.
// Saturation divides by twice the channel sum through a restoring divider spread
// over the same stages, one quotient bit per stage. Reset clears only valid bits.
`default_nettype none
module rgb_to_hsi_converter (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire rth_pkg::chan_t red_i,
  input  wire rth_pkg::chan_t green_i,
  input  wire rth_pkg::chan_t blue_i,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rth_pkg::frac_t      hue_o,
  output rth_pkg::frac_t      saturation_o,
  output rth_pkg::frac_t      intensity_o
);
  import rth_pkg::*;
  localparam int Stages = CordicSteps + 2;
  localparam int NumBits = FracBits + 1 + SumBits;
  localparam int DivSteps = FracBits + 2;

  logic en;
  logic [Stages:0] vld_q;
  assign en = !(vld_q[Stages] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_q[Stages];

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-1:0], in_valid};
    end
  end

  // Stage 0: sum, min, differences, gray flag.
  sum_t s0_sum_q;
  chan_t s0_min_q;
  logic signed [ChanBits+2:0] s0_x_q;
  logic signed [ChanBits+1:0] s0_y_q;
  logic s0_gray_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_sum_q <= SumBits'(red_i) + SumBits'(green_i) + SumBits'(blue_i);
      s0_min_q <= (red_i < green_i) ? ((red_i < blue_i) ? red_i : blue_i)
                                    : ((green_i < blue_i) ? green_i : blue_i);
      s0_x_q <= $signed({3'b0, red_i}) + $signed({3'b0, red_i})
              - $signed({3'b0, green_i}) - $signed({3'b0, blue_i});
      s0_y_q <= $signed({2'b0, green_i}) - $signed({2'b0, blue_i});
      s0_gray_q <= (red_i == green_i) && (green_i == blue_i);
    end
  end

  // Stage 1: CORDIC pre-rotation, divider setup, intensity.
  xy_t xs [Stages-1];
  xy_t ys [Stages-1];
  ang_t as [Stages-1];
  xy_t x1_d, y1_d;
  ang_t a1_d;
  logic gb_eq_q, xpos_q, gray_q [Stages:1];
  logic [NumBits-1:0] num_q [DivSteps:0];
  sum_t den_q [DivSteps:0];
  logic [DivSteps-1:0] quo_q [DivSteps:0];
  frac_t inten_q [Stages:1];
  logic [FracBits+SumBits+1:0] inum;
  logic [IntProdBits-1:0] iprod;

  always_comb begin
    x1_d = xy_t'(s0_x_q) <<< 16;
    y1_d = xy_t'(s0_y_q) * xy_t'(Sqrt3Q16);
    a1_d = '0;
    if (s0_x_q < 0) begin
      x1_d = -x1_d; y1_d = -y1_d; a1_d = HalfTurn;
    end
    inum = ((FracBits+SumBits+2)'(s0_sum_q) << (FracBits + 1))
         + (FracBits+SumBits+2)'(3 * FullScale);
    // Divide by six times full scale through the reciprocal.
    iprod = IntProdBits'(inum) * IntProdBits'(IntRecip);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xs[0] <= x1_d; ys[0] <= y1_d; as[0] <= a1_d;
      gb_eq_q <= (s0_y_q == 0);
      xpos_q <= (s0_x_q > 0);
      num_q[0] <= ((NumBits)'(s0_sum_q - SumBits'(3 * s0_min_q)) << (FracBits + 1))
                + NumBits'(s0_sum_q);
      den_q[0] <= s0_sum_q;
      quo_q[0] <= '0;
    end
  end

  // CORDIC stages.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    rth_cordic_stage u_stage (
      .clk_i(clk_i), .en_i(en), .idx_i(5'(i)),
      .x_i(xs[i]), .y_i(ys[i]), .ang_i(as[i]),
      .x_o(xs[i+1]), .y_o(ys[i+1]), .ang_o(as[i+1])
    );
  end

  // Side pipe: flags and intensity.
  logic gbs_q [Stages:2];
  logic xps_q [Stages:2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      gray_q[1] <= s0_gray_q;
      inten_q[1] <= OutBits'(iprod >> IntShift);
      gbs_q[2] <= gb_eq_q; xps_q[2] <= xpos_q;
      for (int k = 2; k <= Stages; k++) begin
        gray_q[k] <= gray_q[k-1];
        inten_q[k] <= inten_q[k-1];
      end
      for (int k = 3; k <= Stages; k++) begin
        gbs_q[k] <= gbs_q[k-1]; xps_q[k] <= xps_q[k-1];
      end
    end
  end

  // Restoring divider: one quotient bit per stage, the divisor 2*sum.
  for (genvar d = 0; d < DivSteps; d++) begin : g_div
    logic [NumBits:0] rem;
    logic [NumBits:0] dsh;
    always_comb begin
      dsh = (NumBits+1)'({den_q[d], 1'b0}) << (DivSteps - 1 - d);
      rem = {1'b0, num_q[d]};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        den_q[d+1] <= den_q[d];
        if (rem >= dsh) begin
          num_q[d+1] <= NumBits'(rem - dsh);
          quo_q[d+1] <= quo_q[d] | (DivSteps'(1) << (DivSteps - 1 - d));
        end else begin
          num_q[d+1] <= num_q[d];
          quo_q[d+1] <= quo_q[d];
        end
      end
    end
  end

  // Delay the quotient to the output stage.
  localparam int SatDly = Stages - 3 - DivSteps;
  frac_t sat_q [SatDly:0];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_q[0] <= OutBits'(quo_q[DivSteps]);
      for (int k = 1; k <= SatDly; k++) sat_q[k] <= sat_q[k-1];
    end
  end

  // Output stage: hue rounding and special cases.
  frac_t hue_d, hue_q, satv_q, int_q;
  logic [32:0] hr;
  always_comb begin
    hr = {1'b0, as[CordicSteps]} + (33'(1) << (31 - FracBits));
    hue_d = OutBits'(hr >> (32 - FracBits));
    if (gbs_q[Stages-1])
      hue_d = xps_q[Stages-1] ? '0 : OutBits'(1 << (FracBits - 1));
    if (gray_q[Stages-1]) hue_d = '0;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q <= hue_d;
      satv_q <= gray_q[Stages-1] ? '0 : sat_q[SatDly];
      int_q <= inten_q[Stages-1];
    end
  end
  assign hue_o = hue_q;
  assign saturation_o = satv_q;
  assign intensity_o = int_q;
endmodule
`default_nettype wire

// File: sv/rth_checker.sv
// Port-level checker for the HSI converter, bound to the top level.
`default_nettype none
`include "rgb_to_hsi_converter_assert.svh"
module rth_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [12:0] hue_o,
  input wire logic [12:0] saturation_o,
  input wire logic [12:0] intensity_o
);
  `RTH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && out_stall, out_valid && $stable(hue_o), "output not held")
  `RTH_ASSERT_IMP(a_stall_src, clk_i, rst_ni, in_stall, out_valid && out_stall, "stall without cause")
  `RTH_ASSERT_IMP(a_range, clk_i, rst_ni, out_valid, hue_o <= 13'd4096 && saturation_o <= 13'd4096 && intensity_o <= 13'd4096, "out of range")
endmodule
bind rgb_to_hsi_converter rth_checker u_rth_checker (.*);
`default_nettype wire
